>>> src/sh24_pkg.sv
`default_nettype none

package sh24_pkg;

   localparam int LANE_W      = 64;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 8;
   localparam int CSR_INDEX_W = 2;

   typedef logic [LANE_W-1:0]        word_type;
   typedef logic [3:0][LANE_W-1:0]   lanes_type;

   localparam word_type SIP_C0    = 64'h736f6d6570736575;
   localparam word_type SIP_C1    = 64'h646f72616e646f6d;
   localparam word_type SIP_C2    = 64'h6c7967656e657261;
   localparam word_type SIP_C3    = 64'h7465646279746573;
   localparam word_type TWEAK_EE  = 64'h00000000000000ee;
   localparam word_type TWEAK_FF  = 64'h00000000000000ff;
   localparam word_type TWEAK_DD  = 64'h00000000000000dd;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_LOW     = 2'd0,
      CSR_KEY_HIGH    = 2'd1,
      CSR_WIDE_OUTPUT = 2'd2
   } csr_index_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic round;
      logic xor_m;
      logic load_final;
      logic fin_tweak;
      logic capture;
      logic capture_last;
      logic d_tweak;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic word_full;
      logic out_free;
      logic wide_end;
   } status_type;

   function automatic word_type rotl(input word_type v, input int unsigned r);
      return (v << r) | (v >> (LANE_W - r));
   endfunction

   function automatic lanes_type sip_round(input lanes_type v);
      word_type a, b, c, d;
      lanes_type r;
      a = v[0];
      b = v[1];
      c = v[2];
      d = v[3];
      a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
      c = c + d; d = rotl(d, 16); d = d ^ c;
      a = a + d; d = rotl(d, 21); d = d ^ a;
      c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
      r[0] = a;
      r[1] = b;
      r[2] = c;
      r[3] = d;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/sh24_if.sv
`default_nettype none

interface sh24_req_if import sh24_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              byte_present;
   logic              message_end;

   modport source (output valid, output data_byte, output byte_present,
                   output message_end, input ready);
   modport sink   (input valid, input data_byte, input byte_present,
                   input message_end, output ready);
endinterface

interface sh24_rsp_if import sh24_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type digest_word;
   logic     digest_last;

   modport source (output valid, output digest_word, output digest_last, input ready);
   modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

interface sh24_csr_if import sh24_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   word_type               write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

>>> src/siphash_2_4_engine_top.sv
// SipHash-2-4 engine, byte stream in, digest words out.
// Channels (valid/ready, a transaction moves when both are high):
//   req_chan : one message byte per transaction (data_byte, byte_present,
//              message_end). byte_present=0 carries no byte; message_end=1
//              closes the message, an empty message is a single such item.
//   rsp_chan : digest words (digest_word, digest_last); one word in 64-bit
//              mode, two in 128-bit mode, digest_last on the final one.
//   csr_chan : register writes (reg_index, write_data), always ready.
//              0 key_low, 1 key_high, 2 wide_output; other indexes ignored.
// Throughput: one round unit does one SipRound per cycle. Bytes are taken
//   only in S_IDLE; one that completes a 64-bit word (the end item too)
//   first runs its two compression rounds. On message_end: S_FINAL, S_COMP,
//   S_TWEAK, S_FIN, then the first digest word is registered in S_OUT; the
//   second word runs S_FIN again, registered once the first was taken.
// A stalled rsp_chan holds the digest in its output register. After the
//   final word is captured the engine takes bytes of the next message; a
//   digest word that finds the register still full waits, and input waits.
// Reset (synchronous) clears the key and mode registers and starts a fresh
//   message; no clearing pass is needed.
`default_nettype none

module siphash_2_4_engine_top import sh24_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   sh24_req_if.sink   req_chan,
   sh24_rsp_if.source rsp_chan,
   sh24_csr_if.sink   csr_chan
);

   cmd_type    cmd;
   status_type status;

   // register writes never stall
   assign csr_chan.ready = 1'b1;

   sh24_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_message_end (req_chan.message_end),
      .req_ready       (req_chan.ready),
      .status          (status),
      .cmd             (cmd)
   );

   sh24_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data_byte    (req_chan.data_byte),
      .req_byte_present (req_chan.byte_present),
      .req_message_end  (req_chan.message_end),
      .csr_valid        (csr_chan.valid),
      .csr_reg_index    (csr_chan.reg_index),
      .csr_write_data   (csr_chan.write_data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_digest_word  (rsp_chan.digest_word),
      .rsp_digest_last  (rsp_chan.digest_last)
   );

endmodule

`default_nettype wire

>>> src/sh24_ctrl.sv
`default_nettype none

module sh24_ctrl import sh24_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_message_end,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_COMP  = 6'b000010,
      S_FINAL = 6'b000100,
      S_TWEAK = 6'b001000,
      S_FIN   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       end_pend_ff, end_pend_in;
   logic       final_pass_ff, final_pass_in;
   logic       second_ff, second_in;

   always_comb begin
      cmd           = '0;
      req_ready     = 1'b0;
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      end_pend_in   = end_pend_ff;
      final_pass_in = final_pass_ff;
      second_in     = second_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept    = 1'b1;
               end_pend_in   = req_message_end;
               cnt_in        = 2'd0;
               final_pass_in = 1'b0;
               second_in     = 1'b0;
               if (status.word_full) begin
                  state_in = S_COMP;
               end else if (req_message_end) begin
                  state_in = S_FINAL;
               end
            end
         end
         S_COMP: begin
            cmd.round = 1'b1;
            cnt_in    = cnt_ff + 2'd1;
            if (cnt_ff == 2'd1) begin
               cmd.xor_m = 1'b1;
               if (final_pass_ff) begin
                  state_in = S_TWEAK;
               end else if (end_pend_ff) begin
                  state_in = S_FINAL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FINAL: begin
            cmd.load_final = 1'b1;
            final_pass_in  = 1'b1;
            cnt_in         = 2'd0;
            state_in       = S_COMP;
         end
         S_TWEAK: begin
            cmd.fin_tweak = 1'b1;
            cnt_in        = 2'd0;
            state_in      = S_FIN;
         end
         S_FIN: begin
            cmd.round = 1'b1;
            cnt_in    = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.capture      = 1'b1;
               cmd.capture_last = !status.wide_end || second_ff;
               if (cmd.capture_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.d_tweak = 1'b1;
                  second_in   = 1'b1;
                  cnt_in      = 2'd0;
                  state_in    = S_FIN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= 2'd0;
         end_pend_ff   <= 1'b0;
         final_pass_ff <= 1'b0;
         second_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         end_pend_ff   <= end_pend_in;
         final_pass_ff <= final_pass_in;
         second_ff     <= second_in;
      end
   end

   // first of two digest words must loop back for the second
   a_second_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && cmd.capture && !cmd.capture_last)
      |=> (state_ff == S_FIN && second_ff))
      else $error("second digest word not started");

   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_message_end) |=> (state_ff != S_IDLE))
      else $error("message end did not start finalization");

endmodule

`default_nettype wire

>>> src/sh24_dpath.sv
`default_nettype none

module sh24_dpath import sh24_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic [BYTE_W-1:0]      req_data_byte,
   input  wire logic                   req_byte_present,
   input  wire logic                   req_message_end,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_reg_index,
   input  wire word_type               csr_write_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output word_type                    rsp_digest_word,
   output logic                        rsp_digest_last
);

   word_type             key_low_ff, key_high_ff;
   logic                 wide_ff;
   logic                 wide_end_ff;
   logic                 fresh_ff;
   logic [COUNT_W-1:0]   count_ff;
   word_type             packed_ff;
   word_type             m_ff;
   lanes_type            lanes_ff;
   word_type             out_word_ff;
   logic                 out_last_ff;
   logic                 out_valid_ff;

   lanes_type            init_lanes, base_lanes, round_lanes, lanes_in;
   word_type             base_packed, packed_new, final_word, digest;
   logic [COUNT_W-1:0]   base_count, count_new;
   logic                 word_full;

   always_comb begin
      init_lanes[0] = SIP_C0 ^ key_low_ff;
      init_lanes[1] = SIP_C1 ^ key_high_ff ^ (wide_ff ? TWEAK_EE : '0);
      init_lanes[2] = SIP_C2 ^ key_low_ff;
      init_lanes[3] = SIP_C3 ^ key_high_ff;
      base_lanes    = fresh_ff ? init_lanes : lanes_ff;
      base_packed   = fresh_ff ? '0 : packed_ff;
      base_count    = fresh_ff ? '0 : count_ff;
      packed_new    = base_packed;
      count_new     = base_count;
      if (req_byte_present) begin
         packed_new = base_packed
                    | (word_type'(req_data_byte) << {base_count[2:0], 3'b000});
         count_new  = base_count + COUNT_W'(1);
      end
      word_full   = req_byte_present && (base_count[2:0] == 3'b111);
      round_lanes = sip_round(lanes_ff);
      final_word  = packed_ff | {count_ff, {(LANE_W-COUNT_W){1'b0}}};
      digest      = lanes_ff[0] ^ lanes_ff[1] ^ lanes_ff[2] ^ lanes_ff[3];

      // next lane state; the commands below never overlap
      lanes_in = lanes_ff;
      if (cmd.accept) begin
         lanes_in = base_lanes;
         if (word_full) begin
            lanes_in[3] = base_lanes[3] ^ packed_new;
         end
      end
      if (cmd.round) begin
         lanes_in = round_lanes;
         if (cmd.xor_m) begin
            lanes_in[0] = round_lanes[0] ^ m_ff;
         end
      end
      if (cmd.load_final) begin
         lanes_in[3] = lanes_ff[3] ^ final_word;
      end
      if (cmd.fin_tweak) begin
         lanes_in[2] = lanes_ff[2] ^ (wide_end_ff ? TWEAK_EE : TWEAK_FF);
      end
      if (cmd.d_tweak) begin
         lanes_in[1] = lanes_ff[1] ^ TWEAK_DD;
      end
   end

   assign status.word_full = word_full;
   assign status.out_free  = !out_valid_ff || rsp_ready;
   assign status.wide_end  = wide_end_ff;

   assign rsp_valid       = out_valid_ff;
   assign rsp_digest_word = out_word_ff;
   assign rsp_digest_last = out_last_ff;

   // control and register file
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         wide_ff      <= 1'b0;
         fresh_ff     <= 1'b1;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_reg_index)
               CSR_KEY_LOW:     key_low_ff  <= csr_write_data;
               CSR_KEY_HIGH:    key_high_ff <= csr_write_data;
               CSR_WIDE_OUTPUT: wide_ff     <= csr_write_data[0];
               default:         ;
            endcase
         end
         if (cmd.accept) begin
            fresh_ff <= 1'b0;
            count_ff <= count_new;
         end else if (cmd.load_final) begin
            fresh_ff <= 1'b1;
         end
         if (cmd.capture) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // lanes and payload
   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
      if (cmd.accept) begin
         if (word_full) begin
            m_ff        <= packed_new;
            packed_ff   <= '0;
         end else begin
            packed_ff   <= packed_new;
         end
         if (req_message_end) begin
            wide_end_ff <= wide_ff;
         end
      end else if (cmd.load_final) begin
         m_ff        <= final_word;
         packed_ff   <= '0;
      end
      if (cmd.capture) begin
         out_word_ff <= digest;
         out_last_ff <= cmd.capture_last;
      end
   end

   a_capture_free: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (!out_valid_ff || rsp_ready))
      else $error("digest overwrote an unread word");

   a_fresh_after_final: assert property (@(posedge clock) disable iff (reset)
      cmd.load_final |=> fresh_ff)
      else $error("message not closed after final block");

endmodule

`default_nettype wire

>>> tb/sv/tb_siphash_2_4_engine_top.sv
`timescale 1ns / 100ps

import sh24_pkg::*;

typedef struct packed {
   word_type digest_word;
   logic     digest_last;
} digest_entry_type;

// Tracks the engine state, predicts digest words, checks what comes out.
class sip_digest_book;
   word_type         key_lo;
   word_type         key_hi;
   bit               wide;
   word_type         lane [4];
   word_type         partial;
   logic [7:0]       count;
   bit               fresh;
   digest_entry_type pending_digests [$];
   int unsigned      mismatches;

   function new();
      key_lo     = '0;
      key_hi     = '0;
      wide       = 1'b0;
      foreach (lane[i]) lane[i] = '0;
      partial    = '0;
      count      = '0;
      fresh      = 1'b1;
      mismatches = 0;
   endfunction

   function word_type rol(word_type v, int unsigned r);
      logic [127:0] t;
      t = {v, v} << r;
      return t[127:64];
   endfunction

   function void mix_round();
      word_type a, b, c, d;
      a = lane[0]; b = lane[1]; c = lane[2]; d = lane[3];
      a += b; b = rol(b, 13); b ^= a; a = rol(a, 32);
      c += d; d = rol(d, 16); d ^= c;
      a += d; d = rol(d, 21); d ^= a;
      c += b; b = rol(b, 17); b ^= c; c = rol(c, 32);
      lane[0] = a; lane[1] = b; lane[2] = c; lane[3] = d;
   endfunction

   function void compress(word_type m);
      lane[3] ^= m;
      mix_round();
      mix_round();
      lane[0] ^= m;
   endfunction

   function word_type squeeze();
      repeat (4) mix_round();
      return lane[0] ^ lane[1] ^ lane[2] ^ lane[3];
   endfunction

   function void note_config(logic [CSR_INDEX_W-1:0] idx, word_type data);
      case (idx)
         CSR_KEY_LOW:     key_lo = data;
         CSR_KEY_HIGH:    key_hi = data;
         CSR_WIDE_OUTPUT: wide   = data[0];
         default: ;
      endcase
   endfunction

   function void absorb_item(logic [7:0] value, logic present, logic ends_msg);
      if (fresh) begin
         lane[0] = SIP_C0 ^ key_lo;
         lane[1] = SIP_C1 ^ key_hi;
         lane[2] = SIP_C2 ^ key_lo;
         lane[3] = SIP_C3 ^ key_hi;
         if (wide) lane[1] ^= TWEAK_EE;
         partial = '0;
         count   = '0;
         fresh   = 1'b0;
      end
      if (present) begin
         partial |= word_type'(value) << (8 * count[2:0]);
         count++;
         if (count[2:0] == 3'd0) begin
            compress(partial);
            partial = '0;
         end
      end
      if (!ends_msg) return;
      compress(partial | {count, 56'h0});
      partial = '0;
      fresh   = 1'b1;
      if (!wide) begin
         lane[2] ^= TWEAK_FF;
         pending_digests.push_back('{squeeze(), 1'b1});
      end else begin
         lane[2] ^= TWEAK_EE;
         pending_digests.push_back('{squeeze(), 1'b0});
         lane[1] ^= TWEAK_DD;
         pending_digests.push_back('{squeeze(), 1'b1});
      end
   endfunction

   function int unsigned outstanding();
      return pending_digests.size();
   endfunction

   task report(string msg);
      $display("[%0t] digest mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task check_digest(word_type got_word, logic got_last);
      digest_entry_type want;
      if (pending_digests.size() == 0) begin
         report($sformatf("unexpected word %h last %b", got_word, got_last));
         return;
      end
      want = pending_digests.pop_front();
      if (got_word !== want.digest_word)
         report($sformatf("digest_word %h, want %h", got_word, want.digest_word));
      if (got_last !== want.digest_last)
         report($sformatf("digest_last %b, want %b", got_last, want.digest_last));
   endtask

   task close_out();
      if (pending_digests.size() != 0)
         report($sformatf("%0d digest words never arrived", pending_digests.size()));
   endtask
endclass

module tb_siphash_2_4_engine_top;

   // index with no register behind it; writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   // quiet time before a register write, past the worst digest latency
   localparam int SETTLE_CYCLES = 40;
   localparam int ITEM_TARGET   = 1200;

   logic clock;
   logic reset;
   bit   calm;   // when set, neither side inserts bubbles

   sh24_req_if req_if ();
   sh24_rsp_if rsp_if ();
   sh24_csr_if csr_if ();

   sip_digest_book digest_book = new();

   siphash_2_4_engine_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // a bubble on about 14 of every hundred calls unless in a calm stretch
   function automatic bit idle_roll();
      return !calm && ($urandom_range(99) < 14);
   endfunction

   // key values lean toward the all-zero and all-one corners now and then
   function automatic word_type pick_key();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // one request transaction; returns at the edge where it was taken,
   // with valid still high so back-to-back items need no dead cycle
   task automatic send_item(input logic [7:0] value, input logic present,
                            input logic ends_msg);
      while (idle_roll()) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.data_byte    <= value;
      req_if.byte_present <= present;
      req_if.message_end  <= ends_msg;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      digest_book.absorb_item(value, present, ends_msg);
   endtask

   // register write transaction; drops valid again before returning
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input word_type data);
      csr_if.valid      <= 1'b1;
      csr_if.reg_index  <= idx;
      csr_if.write_data <= data;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      digest_book.note_config(idx, data);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending, let every digest drain, then give the engine time to
   // finish any compression still in flight (items with no result)
   task automatic settle();
      req_if.valid <= 1'b0;
      while (digest_book.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: random back-pressure, same bubble rate as the sender
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !idle_roll();
      end
   end

   // every digest transaction is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         digest_book.check_digest(rsp_if.digest_word, rsp_if.digest_last);
   end

   initial begin
      logic [7:0] mixed_bytes [7];
      int         sent;
      int         msg_no;
      int         len;
      int         split;

      calm                <= 1'b0;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.data_byte    <= '0;
      req_if.byte_present <= 1'b0;
      req_if.message_end  <= 1'b0;
      csr_if.valid        <= 1'b0;
      csr_if.reg_index    <= '0;
      csr_if.write_data   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // standard test key 00..0f; spare index must not disturb anything
      csr_write(CSR_KEY_LOW, 64'h0706050403020100);
      csr_write(CSR_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
      csr_write(CSR_WIDE_OUTPUT, 64'h0);
      csr_write(CSR_SPARE_INDEX, '1);

      // empty message, 64-bit digest
      send_item(8'h00, 1'b0, 1'b1);
      settle();

      // empty message, 128-bit digest; data ignored without byte_present
      csr_write(CSR_WIDE_OUTPUT, 64'h1);
      send_item(8'hff, 1'b0, 1'b1);
      settle();

      // eight bytes, the last one on the end item fills the word
      mixed_bytes = '{8'h00, 8'hff, 8'h80, 8'h01, 8'h7f, 8'haa, 8'h55};
      foreach (mixed_bytes[k]) send_item(mixed_bytes[k], 1'b1, 1'b0);
      send_item(8'hc3, 1'b1, 1'b1);
      settle();

      // empty item inside a message
      csr_write(CSR_WIDE_OUTPUT, 64'h0);
      send_item(8'h5a, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h3c, 1'b1, 1'b1);
      settle();

      // mode flips 128 -> 64 mid-message; key change waits for next message
      csr_write(CSR_WIDE_OUTPUT, 64'h1);
      send_item(8'h12, 1'b1, 1'b0);
      send_item(8'h34, 1'b1, 1'b0);
      settle();
      csr_write(CSR_WIDE_OUTPUT, 64'h0);
      csr_write(CSR_KEY_LOW, '1);
      send_item(8'h56, 1'b1, 1'b1);
      settle();

      // mode flips 64 -> 128 mid-message, empty end item
      send_item(8'h9a, 1'b1, 1'b0);
      settle();
      csr_write(CSR_WIDE_OUTPUT, 64'h1);
      csr_write(CSR_KEY_HIGH, '1);
      send_item(8'h00, 1'b0, 1'b1);
      settle();

      // all-ones key, single byte on the end item
      send_item(8'hff, 1'b1, 1'b1);
      settle();

      // all-zero key; an empty item opens the message
      csr_write(CSR_KEY_LOW, '0);
      csr_write(CSR_KEY_HIGH, '0);
      csr_write(CSR_WIDE_OUTPUT, 64'h0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h01, 1'b1, 1'b1);
      settle();

      // ---- random part: well-formed messages with random content ----
      sent   = 0;
      msg_no = 0;
      while (sent < ITEM_TARGET) begin
         if (msg_no % 6 == 5) begin
            settle();
            csr_write(CSR_KEY_LOW, pick_key());
            csr_write(CSR_KEY_HIGH, pick_key());
            csr_write(CSR_WIDE_OUTPUT, {$urandom, $urandom});
         end
         // one message long enough to wrap the length byte
         if (msg_no == 3)
            len = 256 + $urandom_range(24);
         else if ($urandom_range(99) < 3)
            len = $urandom_range(140, 64);
         else
            len = $urandom_range(20);
         split = -1;
         if (len > 1 && $urandom_range(15) == 0)
            split = $urandom_range(len - 1, 1);
         calm = (sent >= 400 && sent < 600);
         for (int k = 0; k < len; k++) begin
            if (k == split) begin
               // register change while a message is open
               settle();
               csr_write(CSR_WIDE_OUTPUT, {$urandom, $urandom});
               if ($urandom_range(1)) csr_write(CSR_KEY_LOW, pick_key());
            end
            if ($urandom_range(11) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, 1'b0);
            sent++;
         end
         send_item(8'($urandom), 1'($urandom_range(1)), 1'b1);
         sent++;
         msg_no++;
      end
      calm = 1'b0;

      settle();
      digest_book.close_out();
      if (digest_book.mismatches == 0) begin
         $display("siphash_2_4_engine_top verification clean");
      end else begin
         $display("siphash_2_4_engine_top verification failed");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("siphash_2_4_engine_top verification failed");
      $finish;
   end

endmodule
